>>> src/aspseq_pkg.sv
package aspseq_pkg;

	// Event codes carried in req_type
	typedef enum logic [1:0] {
		EV_START   = 2'd0,
		EV_DONE    = 2'd1,
		EV_TIMEOUT = 2'd2,
		EV_POLL    = 2'd3
	} event_t;

	// Driver mode reported in driver_mode
	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_IDLE  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_FAULT = 2'd3
	} mode_t;

	// Steps of the configure-and-verify sequence
	typedef enum logic [1:0] {
		STEP_WAIT_START = 2'd0,
		STEP_WAIT_WRITE = 2'd1,
		STEP_WAIT_CHECK = 2'd2
	} step_t;

	// Register indexes on the configuration port
	localparam logic REG_CONTROL_WORD  = 1'b0;
	localparam logic REG_ATTEMPT_LIMIT = 1'b1;

	localparam int PADDR_W = 3;

	localparam logic [7:0] RESET_CONTROL_WORD  = 8'h67;
	localparam logic [3:0] RESET_ATTEMPT_LIMIT = 4'd3;

	localparam logic [7:0] READ_FLAG = 8'h80;
	localparam logic [7:0] CTRL_ADDR = 8'h20;
	localparam logic [7:0] OUT_ADDR  = 8'h28;

	localparam logic [2:0] LEN_SHORT = 3'd2;
	localparam logic [2:0] LEN_BURST = 3'd7;

	localparam logic [3:0] ATTEMPT_MAX = 4'd15;

	typedef struct packed {
		logic [7:0] control_word;
		logic [3:0] attempt_limit;
	} cfg_t;

endpackage

>>> src/aspseq_if.sv
interface aspseq_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte_1;
	logic [7:0] rx_byte_2;
	logic [7:0] rx_byte_3;
	logic [7:0] rx_byte_4;
	logic [7:0] rx_byte_5;
	logic [7:0] rx_byte_6;

	modport source (
		output valid, req_type, rx_byte_1, rx_byte_2, rx_byte_3,
			rx_byte_4, rx_byte_5, rx_byte_6,
		input  ready
	);
	modport sink (
		input  valid, req_type, rx_byte_1, rx_byte_2, rx_byte_3,
			rx_byte_4, rx_byte_5, rx_byte_6,
		output ready
	);
endinterface

interface aspseq_res_if;
	logic               valid;
	logic               ready;
	logic               transfer_request;
	logic [2:0]         transfer_length;
	logic [7:0]         tx_first_byte;
	logic [7:0]         tx_second_byte;
	logic [1:0]         driver_mode;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic               arm_poll_timer;
	logic               disarm_poll_timer;
	logic               event_error;

	modport source (
		output valid, transfer_request, transfer_length, tx_first_byte,
			tx_second_byte, driver_mode, accel_x, accel_y, accel_z,
			arm_poll_timer, disarm_poll_timer, event_error,
		input  ready
	);
	modport sink (
		input  valid, transfer_request, transfer_length, tx_first_byte,
			tx_second_byte, driver_mode, accel_x, accel_y, accel_z,
			arm_poll_timer, disarm_poll_timer, event_error,
		output ready
	);
endinterface

>>> src/aspseq_regs.sv
module aspseq_regs
	import aspseq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_word  <= RESET_CONTROL_WORD;
			cfg_q.attempt_limit <= RESET_ATTEMPT_LIMIT;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CONTROL_WORD:  cfg_q.control_word  <= pwdata[7:0];
				REG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CONTROL_WORD:  prdata = {24'd0, cfg_q.control_word};
			REG_ATTEMPT_LIMIT: prdata = {28'd0, cfg_q.attempt_limit};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

>>> src/accel_sensor_poll_sequencer.sv
// Sequencer for an SPI accelerometer: it writes the control word, reads it
// back to verify it, then polls the sensor for X/Y/Z samples on each tick.
//
// Channels: evt carries one event word (req_type plus six received bytes),
// res carries one result word per event (transfer request, mode, axes,
// timer flags, error flag). Both use valid/ready; a word moves when both are
// high. The APB port holds control_word (0x0) and attempt_limit (0x4).
//
// An accepted event word is held in the event register, evaluated against
// the state, and its result is registered in the result register.
// Throughput: one event per cycle while res is not stalled, set by the
// single state update between the event register and the result register.
//
// Reset: arst_n clears the mode to initialising, the sequence step and the
// attempt count to zero, the axes to zero, and loads the register defaults
// (control word 0x67, attempt limit 3). No result is pending after reset.
//
// Stall: while res is stalled the result word holds; one more event word
// is held in the event register, after which evt.ready drops until the
// receiver takes the result.
module accel_sensor_poll_sequencer
	import aspseq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	aspseq_evt_if.sink         evt,
	aspseq_res_if.source       res
);

	cfg_t cfg;

	aspseq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Event register (stage 1)
	logic       valid_s1;
	event_t     ev_s1;
	logic [7:0] rx1_s1, rx2_s1, rx3_s1, rx4_s1, rx5_s1, rx6_s1;

	// Sequencer state
	mode_t       mode_q;
	step_t       step_q;
	logic [3:0]  attempt_q;
	logic [15:0] ax_q, ay_q, az_q;

	// Result register (stage 2)
	logic        valid_s2;
	logic        req_s2;
	logic [2:0]  len_s2;
	logic [7:0]  tx0_s2, tx1_s2;
	logic        arm_s2, disarm_s2, err_s2;

	// Next-state and result terms
	mode_t       mode_d;
	step_t       step_d;
	logic [3:0]  attempt_d;
	logic [3:0]  attempt_inc;
	logic [15:0] ax_d, ay_d, az_d;
	logic        req_d;
	logic [2:0]  len_d;
	logic [7:0]  tx0_d, tx1_d;
	logic        arm_d, disarm_d, err_d;

	logic advance;

	// Evaluate the held event when the result slot is free or being emptied
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			ev_s1  <= event_t'(evt.req_type);
			rx1_s1 <= evt.rx_byte_1;
			rx2_s1 <= evt.rx_byte_2;
			rx3_s1 <= evt.rx_byte_3;
			rx4_s1 <= evt.rx_byte_4;
			rx5_s1 <= evt.rx_byte_5;
			rx6_s1 <= evt.rx_byte_6;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INIT;
			step_q    <= STEP_WAIT_START;
			attempt_q <= 4'd0;
			ax_q      <= 16'd0;
			ay_q      <= 16'd0;
			az_q      <= 16'd0;
		end else if (advance) begin
			mode_q    <= mode_d;
			step_q    <= step_d;
			attempt_q <= attempt_d;
			ax_q      <= ax_d;
			ay_q      <= ay_d;
			az_q      <= az_d;
		end
	end

	// Count one failed verification, saturating
	assign attempt_inc = (attempt_q < ATTEMPT_MAX) ? attempt_q + 4'd1 : attempt_q;

	always_comb begin
		mode_d    = mode_q;
		step_d    = step_q;
		attempt_d = attempt_q;
		ax_d      = ax_q;
		ay_d      = ay_q;
		az_d      = az_q;
		req_d     = 1'b0;
		len_d     = 3'd0;
		tx0_d     = 8'd0;
		tx1_d     = 8'd0;
		arm_d     = 1'b0;
		disarm_d  = 1'b0;
		err_d     = 1'b0;

		unique case (mode_q)
			MODE_INIT: begin
				unique case (ev_s1)
					EV_START: begin
						if (step_q == STEP_WAIT_START) begin
							step_d = STEP_WAIT_WRITE;
							req_d  = 1'b1;
							len_d  = LEN_SHORT;
							tx0_d  = CTRL_ADDR;
							tx1_d  = cfg.control_word;
						end else begin
							err_d = 1'b1;
						end
					end
					EV_DONE: begin
						unique case (step_q)
							STEP_WAIT_WRITE: begin
								// Write landed: read the control register back
								step_d = STEP_WAIT_CHECK;
								req_d  = 1'b1;
								len_d  = LEN_SHORT;
								tx0_d  = READ_FLAG | CTRL_ADDR;
							end
							STEP_WAIT_CHECK: begin
								if (rx1_s1 == cfg.control_word) begin
									mode_d = MODE_IDLE;
									arm_d  = 1'b1;
								end else begin
									step_d    = STEP_WAIT_START;
									attempt_d = attempt_inc;
									if (attempt_inc >= cfg.attempt_limit) begin
										mode_d   = MODE_FAULT;
										ax_d     = 16'd0;
										ay_d     = 16'd0;
										az_d     = 16'd0;
										disarm_d = 1'b1;
									end else begin
										// Retry the write
										step_d = STEP_WAIT_WRITE;
										req_d  = 1'b1;
										len_d  = LEN_SHORT;
										tx0_d  = CTRL_ADDR;
										tx1_d  = cfg.control_word;
									end
								end
							end
							default: err_d = 1'b1;
						endcase
					end
					EV_TIMEOUT: begin
						mode_d   = MODE_FAULT;
						ax_d     = 16'd0;
						ay_d     = 16'd0;
						az_d     = 16'd0;
						disarm_d = 1'b1;
					end
					EV_POLL: ;
					default: ;
				endcase
			end
			MODE_IDLE: begin
				unique case (ev_s1)
					EV_START: err_d = 1'b1;
					EV_TIMEOUT: begin
						mode_d   = MODE_FAULT;
						ax_d     = 16'd0;
						ay_d     = 16'd0;
						az_d     = 16'd0;
						disarm_d = 1'b1;
					end
					EV_POLL: begin
						mode_d = MODE_READ;
						req_d  = 1'b1;
						len_d  = LEN_BURST;
						tx0_d  = READ_FLAG | OUT_ADDR;
					end
					EV_DONE: ;
					default: ;
				endcase
			end
			MODE_READ: begin
				unique case (ev_s1)
					EV_START: err_d = 1'b1;
					EV_TIMEOUT: begin
						mode_d   = MODE_FAULT;
						ax_d     = 16'd0;
						ay_d     = 16'd0;
						az_d     = 16'd0;
						disarm_d = 1'b1;
					end
					EV_DONE: begin
						// Pack little-endian axis pairs
						ax_d   = {rx2_s1, rx1_s1};
						ay_d   = {rx4_s1, rx3_s1};
						az_d   = {rx6_s1, rx5_s1};
						mode_d = MODE_IDLE;
					end
					EV_POLL: ;
					default: ;
				endcase
			end
			MODE_FAULT: ;  // drop every event
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			req_s2    <= req_d;
			len_s2    <= len_d;
			tx0_s2    <= tx0_d;
			tx1_s2    <= tx1_d;
			arm_s2    <= arm_d;
			disarm_s2 <= disarm_d;
			err_s2    <= err_d;
		end
	end

	// Mode and axes after the event are the state registers themselves
	assign res.valid             = valid_s2;
	assign res.transfer_request  = req_s2;
	assign res.transfer_length   = len_s2;
	assign res.tx_first_byte     = tx0_s2;
	assign res.tx_second_byte    = tx1_s2;
	assign res.driver_mode       = mode_q;
	assign res.accel_x           = $signed(ax_q);
	assign res.accel_y           = $signed(ay_q);
	assign res.accel_z           = $signed(az_q);
	assign res.arm_poll_timer    = arm_s2;
	assign res.disarm_poll_timer = disarm_s2;
	assign res.event_error       = err_s2;

	// Fault is terminal until reset
	a_fault_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_FAULT |=> mode_q == MODE_FAULT)
		else $error("fault mode left without reset");

	// A disarm is only reported together with fault mode and cleared X and Z axes
	a_disarm_fault: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.disarm_poll_timer |->
			res.driver_mode == MODE_FAULT && ax_q == 16'd0 && az_q == 16'd0)
		else $error("disarm without fault");

	// A timer arm only accompanies entry to idle
	a_arm_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.arm_poll_timer |-> res.driver_mode == MODE_IDLE)
		else $error("arm outside idle");

	// Input backpressure only while both stages are full and output stalled
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> valid_s1 && valid_s2 && !res.ready)
		else $error("event channel stalled with room to spare");

endmodule
